// ----- src/rkw_pkg.sv -----
`timescale 1ns / 1ps

package rkw_pkg;

	// Window geometry
	localparam int WINDOW_BYTES = 32;
	localparam int TALLY_W = 6;
	localparam int SUM_W = 16;
	localparam int ENTROPY_W = 11;
	localparam int DELTA_W = 11;

	// Running sum is kept with the rounding offset of the final scaling folded in
	localparam logic [SUM_W-1:0] SUM_BIAS = 16'd16;
	localparam logic [ENTROPY_W-1:0] ENTROPY_MAX = 11'd1280;
	localparam logic [TALLY_W-1:0] WINDOW_FULL = 6'd32;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	// Configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENTROPY_THRESHOLD = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ZERO_BYTES = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ONES_BYTES = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DISTINCT = 4'd3;

	localparam logic [11:0] RST_ENTROPY_THRESHOLD = 12'd1664;
	localparam logic [TALLY_W-1:0] RST_MAX_ZERO_BYTES = 6'd4;
	localparam logic [TALLY_W-1:0] RST_MAX_ONES_BYTES = 6'd4;
	localparam logic [TALLY_W-1:0] RST_MIN_DISTINCT = 6'd16;

	typedef enum logic [2:0] {
		REASON_PASS,
		REASON_SHORT,
		REASON_LOW_ENTROPY,
		REASON_ZERO_FF,
		REASON_FEW_DISTINCT
	} reason_t;

	// Histogram write port
	typedef struct packed {
		logic                en;
		logic [7:0]          addr;
		logic [TALLY_W-1:0]  cnt;
	} hist_wr_t;

	// Increment of round(256*c*log2(c)) when a count goes from c to c+1
	localparam logic [DELTA_W-1:0] CLOGC_DELTA [32] = '{
		11'd0,    11'd512,  11'd705,  11'd831,  11'd924,  11'd999,  11'd1060, 11'd1113,
		11'd1160, 11'd1200, 11'd1238, 11'd1271, 11'd1302, 11'd1331, 11'd1356, 11'd1382,
		11'd1405, 11'd1426, 11'd1447, 11'd1466, 11'd1485, 11'd1503, 11'd1519, 11'd1535,
		11'd1551, 11'd1565, 11'd1580, 11'd1593, 11'd1607, 11'd1619, 11'd1632, 11'd1643
	};

endpackage

// ----- src/rkw_ifs.sv -----
`timescale 1ns / 1ps

// Byte stream into the detector
interface rkw_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// Verdict for each buffer
interface rkw_verdict_if;
	logic        valid;
	logic        ready;
	logic        is_key_like;
	logic [2:0]  fail_reason;
	logic [10:0] entropy_value;
	logic [5:0]  distinct_count;

	modport source (output valid, output is_key_like, output fail_reason,
		output entropy_value, output distinct_count, input ready);
	modport sink (input valid, input is_key_like, input fail_reason,
		input entropy_value, input distinct_count, output ready);
endinterface

// Register write channel
interface rkw_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [11:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/rkw_hist.sv -----
`timescale 1ns / 1ps

module rkw_hist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [7:0]                    rd_addr,
	input  logic [7:0]                    look_addr,
	input  rkw_pkg::hist_wr_t             wr,
	input  logic                          clear,
	output logic [rkw_pkg::TALLY_W-1:0]   count
);

	logic [rkw_pkg::TALLY_W-1:0] mem [256];
	logic [rkw_pkg::TALLY_W-1:0] rd_q;
	logic [255:0]                valid_q;
	logic                        fwd_valid_q;
	logic [7:0]                  fwd_addr_q;
	logic [rkw_pkg::TALLY_W-1:0] fwd_cnt_q;

	// Count storage: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.cnt;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Entry valid bits; clear drops the whole window at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Hold the last write to bypass a read that raced it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (clear) begin
			fwd_valid_q <= 1'b0;
		end else if (wr.en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			fwd_addr_q <= wr.addr;
			fwd_cnt_q  <= wr.cnt;
		end
	end

	// Resolve the current count of the byte in flight
	always_comb begin
		if (!valid_q[look_addr]) begin
			count = '0;
		end else if (fwd_valid_q && fwd_addr_q == look_addr) begin
			count = fwd_cnt_q;
		end else begin
			count = rd_q;
		end
	end

`ifndef NO_ASSERTIONS
	// A cleared window leaves no entry counted
	assert property (@(posedge clk) disable iff (!arst_n) clear |=> valid_q == '0)
		else $error("histogram not cleared");
	// The bypass always refers to an entry that is live
	assert property (@(posedge clk) disable iff (!arst_n) fwd_valid_q |-> valid_q[fwd_addr_q])
		else $error("bypass entry not valid");
	// A count never exceeds the window
	assert property (@(posedge clk) disable iff (!arst_n) count <= rkw_pkg::WINDOW_FULL)
		else $error("histogram count out of range");
`endif

endmodule

// ----- src/random_key_window_detector.sv -----
`timescale 1ns / 1ps

// Byte-stream randomness detector. Bytes arrive on stream, the last byte of a buffer
// flagged with end_of_buffer; the first 32 bytes of each buffer build a histogram,
// a c*log2(c) sum and zero/0xFF/distinct tallies, and the end byte yields one verdict
// on the verdict channel (is_key_like, fail_reason, entropy_value in 1/256 bit, and
// distinct_count). Throughput is one byte per clock with no gaps between buffers; the
// verdict is registered as the end byte leaves the input stage. The histogram is a
// 256-entry memory read as a byte is accepted and written from the input stage, with
// a bypass of the last write, and per-entry valid flops that empty it at once at each
// buffer end, so there is no clearing pass after reset. Input stalls only while a
// verdict waits at the output and the next end byte needs the output register.
// Registers (cfg index): 0 entropy_threshold, 1 max_zero_bytes, 2 max_ones_bytes,
// 3 min_distinct; writes to other indexes are dropped.
module random_key_window_detector (
	input logic           clk,
	input logic           arst_n,
	rkw_stream_if.sink    stream,
	rkw_verdict_if.source verdict,
	rkw_cfg_if.sink       cfg
);

	localparam int TW = rkw_pkg::TALLY_W;

	// Configuration registers
	logic [11:0]   entropy_threshold_q;
	logic [TW-1:0] max_zero_bytes_q;
	logic [TW-1:0] max_ones_bytes_q;
	logic [TW-1:0] min_distinct_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Window state
	logic [TW-1:0]             bytes_taken_q;
	logic [rkw_pkg::SUM_W-1:0] sum_q;
	logic [TW-1:0]             zero_tally_q;
	logic [TW-1:0]             ones_tally_q;
	logic [TW-1:0]             distinct_tally_q;

	// Result register
	logic                          out_valid_q;
	rkw_pkg::reason_t              reason_q;
	logic [rkw_pkg::ENTROPY_W-1:0] entropy_q;
	logic [TW-1:0]                 distinct_q;

	logic                          in_fire;
	logic                          s1_fire;
	logic                          take;
	logic [TW-1:0]                 count;
	logic [4:0]                    count_idx;
	rkw_pkg::hist_wr_t             hist_wr;
	logic                          window_clear;
	logic [TW-1:0]                 taken_next;
	logic [rkw_pkg::SUM_W-1:0]     sum_next;
	logic [TW-1:0]                 zero_next;
	logic [TW-1:0]                 ones_next;
	logic [TW-1:0]                 distinct_next;
	logic [rkw_pkg::ENTROPY_W-1:0] drop;
	logic [rkw_pkg::ENTROPY_W-1:0] entropy;
	rkw_pkg::reason_t              reason;

	// Handshakes
	assign in_fire = stream.valid && stream.ready;
	assign s1_fire = valid_s1 && !(end_s1 && out_valid_q && !verdict.ready);
	assign stream.ready = !valid_s1 || s1_fire;
	assign cfg.ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entropy_threshold_q <= rkw_pkg::RST_ENTROPY_THRESHOLD;
			max_zero_bytes_q    <= rkw_pkg::RST_MAX_ZERO_BYTES;
			max_ones_bytes_q    <= rkw_pkg::RST_MAX_ONES_BYTES;
			min_distinct_q      <= rkw_pkg::RST_MIN_DISTINCT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rkw_pkg::CFG_ENTROPY_THRESHOLD: entropy_threshold_q <= cfg.data;
				rkw_pkg::CFG_MAX_ZERO_BYTES:    max_zero_bytes_q <= cfg.data[TW-1:0];
				rkw_pkg::CFG_MAX_ONES_BYTES:    max_ones_bytes_q <= cfg.data[TW-1:0];
				rkw_pkg::CFG_MIN_DISTINCT:      min_distinct_q <= cfg.data[TW-1:0];
				default: ;
			endcase
		end
	end

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_s1 <= '0;
			end_s1  <= 1'b0;
		end else if (in_fire) begin
			byte_s1 <= stream.data_byte;
			end_s1  <= stream.end_of_buffer;
		end
	end

	// Histogram lookup and update
	assign take = bytes_taken_q != rkw_pkg::WINDOW_FULL;
	assign window_clear = s1_fire && end_s1;
	assign hist_wr = '{en: s1_fire && take, addr: byte_s1, cnt: count + 6'd1};

	rkw_hist u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_fire),
		.rd_addr   (stream.data_byte),
		.look_addr (byte_s1),
		.wr        (hist_wr),
		.clear     (window_clear),
		.count     (count)
	);

	// Window tallies after this byte
	always_comb begin
		count_idx     = count[TW-1] ? 5'd31 : count[4:0];
		taken_next    = bytes_taken_q;
		sum_next      = sum_q;
		zero_next     = zero_tally_q;
		ones_next     = ones_tally_q;
		distinct_next = distinct_tally_q;
		if (take) begin
			taken_next = bytes_taken_q + 6'd1;
			sum_next   = sum_q + {5'd0, rkw_pkg::CLOGC_DELTA[count_idx]};
			if (count == '0) begin
				distinct_next = distinct_tally_q + 6'd1;
			end
			if (byte_s1 == rkw_pkg::BYTE_ZERO) begin
				zero_next = zero_tally_q + 6'd1;
			end
			if (byte_s1 == rkw_pkg::BYTE_ONES) begin
				ones_next = ones_tally_q + 6'd1;
			end
		end
	end

	// Verdict on the finished window
	always_comb begin
		drop    = sum_next[rkw_pkg::SUM_W-1:5];
		entropy = (drop >= rkw_pkg::ENTROPY_MAX) ? '0 : rkw_pkg::ENTROPY_MAX - drop;
		if (taken_next != rkw_pkg::WINDOW_FULL) begin
			reason  = rkw_pkg::REASON_SHORT;
			entropy = '0;
		end else if ({1'b0, entropy} < entropy_threshold_q) begin
			reason = rkw_pkg::REASON_LOW_ENTROPY;
		end else if (zero_next > max_zero_bytes_q || ones_next > max_ones_bytes_q) begin
			reason = rkw_pkg::REASON_ZERO_FF;
		end else if (distinct_next < min_distinct_q) begin
			reason = rkw_pkg::REASON_FEW_DISTINCT;
		end else begin
			reason = rkw_pkg::REASON_PASS;
		end
	end

	// Advance the window state, drop it at buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_taken_q    <= '0;
			sum_q            <= rkw_pkg::SUM_BIAS;
			zero_tally_q     <= '0;
			ones_tally_q     <= '0;
			distinct_tally_q <= '0;
		end else if (window_clear) begin
			bytes_taken_q    <= '0;
			sum_q            <= rkw_pkg::SUM_BIAS;
			zero_tally_q     <= '0;
			ones_tally_q     <= '0;
			distinct_tally_q <= '0;
		end else if (s1_fire) begin
			bytes_taken_q    <= taken_next;
			sum_q            <= sum_next;
			zero_tally_q     <= zero_next;
			ones_tally_q     <= ones_next;
			distinct_tally_q <= distinct_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (window_clear) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (window_clear) begin
			reason_q   <= reason;
			entropy_q  <= entropy;
			distinct_q <= distinct_next;
		end
	end

	assign verdict.valid          = out_valid_q;
	assign verdict.is_key_like    = reason_q == rkw_pkg::REASON_PASS;
	assign verdict.fail_reason    = reason_q;
	assign verdict.entropy_value  = entropy_q;
	assign verdict.distinct_count = distinct_q;

`ifndef NO_ASSERTIONS
	// Every retired end byte leaves a verdict waiting
	assert property (@(posedge clk) disable iff (!arst_n) window_clear |=> out_valid_q)
		else $error("end byte produced no verdict");
	// A pending verdict is never overwritten before it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !verdict.ready |-> !window_clear)
		else $error("verdict overwritten");
	// The window never grows past its length
	assert property (@(posedge clk) disable iff (!arst_n)
		bytes_taken_q <= rkw_pkg::WINDOW_FULL)
		else $error("window overrun");
	// Distinct values cannot outnumber the bytes seen
	assert property (@(posedge clk) disable iff (!arst_n)
		distinct_tally_q <= bytes_taken_q)
		else $error("distinct tally exceeds bytes taken");
`endif

endmodule

// ----- bench/rkw_verdict_checker.sv -----
`timescale 1ns / 1ps

// Watches the byte, verdict and register channels, predicts each verdict and
// compares it field by field with what the detector hands out.
module rkw_verdict_checker
	import rkw_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	rkw_stream_if  stream,
	rkw_verdict_if verdict,
	rkw_cfg_if     cfg,
	output int     fail_count,
	output int     outstanding
);

	typedef struct {
		logic        key_like;
		reason_t     reason;
		logic [10:0] entropy;
		logic [5:0]  distinct;
	} verdict_t;

	// round(256 * c * log2(c)) for c = 0..32
	localparam logic [15:0] CLOGC_LUT [33] = '{
		16'd0,     16'd0,     16'd512,   16'd1217,  16'd2048,  16'd2972,  16'd3971,
		16'd5031,  16'd6144,  16'd7304,  16'd8504,  16'd9742,  16'd11013, 16'd12315,
		16'd13646, 16'd15002, 16'd16384, 16'd17789, 16'd19215, 16'd20662, 16'd22128,
		16'd23613, 16'd25116, 16'd26635, 16'd28170, 16'd29721, 16'd31286, 16'd32866,
		16'd34459, 16'd36066, 16'd37685, 16'd39317, 16'd40960
	};

	// Register copies
	logic [11:0] entropy_floor;
	logic [5:0]  zero_limit;
	logic [5:0]  ones_limit;
	logic [5:0]  distinct_floor;

	// Window state
	logic [5:0]  byte_counts [256];
	logic [5:0]  window_fill;
	logic [15:0] clogc_acc;
	logic [5:0]  zero_seen;
	logic [5:0]  ones_seen;
	logic [5:0]  distinct_seen;

	verdict_t verdict_q [$];
	int       errors = 0;

	task automatic clear_window();
		for (int i = 0; i < 256; i++)
			byte_counts[i] = '0;
		window_fill = '0;
		clogc_acc = '0;
		zero_seen = '0;
		ones_seen = '0;
		distinct_seen = '0;
	endtask

	// Fold one byte into the window; on the end mark queue the verdict and clear
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		logic [5:0]  c;
		logic [16:0] drop;
		verdict_t    v;
		if (window_fill < WINDOW_FULL) begin
			c = byte_counts[b];
			if (c > 6'd31)
				c = 6'd31;
			if (c == 6'd0)
				distinct_seen++;
			clogc_acc = clogc_acc + CLOGC_LUT[c + 6'd1] - CLOGC_LUT[c];
			byte_counts[b] = c + 6'd1;
			if (b == BYTE_ZERO)
				zero_seen++;
			if (b == BYTE_ONES)
				ones_seen++;
			window_fill++;
		end
		if (last) begin
			v.entropy = '0;
			v.distinct = distinct_seen;
			if (window_fill < WINDOW_FULL) begin
				v.reason = REASON_SHORT;
			end else begin
				drop = ({1'b0, clogc_acc} + 17'd16) >> 5;
				if (drop < 17'd1280)
					v.entropy = 11'(17'd1280 - drop);
				if ({1'b0, v.entropy} < entropy_floor)
					v.reason = REASON_LOW_ENTROPY;
				else if (zero_seen > zero_limit || ones_seen > ones_limit)
					v.reason = REASON_ZERO_FF;
				else if (distinct_seen < distinct_floor)
					v.reason = REASON_FEW_DISTINCT;
				else
					v.reason = REASON_PASS;
			end
			v.key_like = (v.reason == REASON_PASS);
			verdict_q.push_back(v);
			clear_window();
		end
	endtask

	function automatic void check_field(input string field, input logic [11:0] want,
		input logic [11:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	// Compare verdicts first so a verdict cannot match a byte taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		verdict_t exp_v;
		if (!arst_n) begin
			entropy_floor = RST_ENTROPY_THRESHOLD;
			zero_limit = RST_MAX_ZERO_BYTES;
			ones_limit = RST_MAX_ONES_BYTES;
			distinct_floor = RST_MIN_DISTINCT;
			clear_window();
			verdict_q.delete();
		end else begin
			if (verdict.valid && verdict.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: verdict with none expected, reason %0d entropy %0d",
						$time, verdict.fail_reason, verdict.entropy_value);
					errors++;
				end else begin
					exp_v = verdict_q.pop_front();
					check_field("is_key_like", 12'(exp_v.key_like), 12'(verdict.is_key_like));
					check_field("fail_reason", 12'(exp_v.reason), 12'(verdict.fail_reason));
					check_field("entropy_value", 12'(exp_v.entropy),
						12'(verdict.entropy_value));
					check_field("distinct_count", 12'(exp_v.distinct),
						12'(verdict.distinct_count));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ENTROPY_THRESHOLD: entropy_floor = cfg.data;
					CFG_MAX_ZERO_BYTES:    zero_limit = cfg.data[5:0];
					CFG_MAX_ONES_BYTES:    ones_limit = cfg.data[5:0];
					CFG_MIN_DISTINCT:      distinct_floor = cfg.data[5:0];
					default: ;
				endcase
			end
			if (stream.valid && stream.ready)
				absorb_byte(stream.data_byte, stream.end_of_buffer);
		end
		outstanding <= verdict_q.size();
		fail_count <= errors;
	end

endmodule

// ----- bench/random_key_window_detector_tb.sv -----
`timescale 1ns / 1ps

module random_key_window_detector_tb;
	import rkw_pkg::*;

	localparam int RANDOM_ITEMS = 560;
	localparam int MIN_VERDICTS = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;

	typedef logic [7:0] byte_seq_t [$];

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   idle_cycles = 0;
	int   burst_left = 0;
	int   taken_items = 0;
	int   buffers_sent = 0;

	rkw_stream_if  stream ();
	rkw_verdict_if verdict ();
	rkw_cfg_if     cfg ();

	random_key_window_detector uut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.verdict(verdict),
		.cfg(cfg)
	);

	rkw_verdict_checker verdict_chk (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.verdict(verdict),
		.cfg(cfg),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// End the run when no channel has moved a transaction for too long
	always @(posedge clk) begin
		if ((stream.valid && stream.ready) || (verdict.valid && verdict.ready)
			|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Verdict backpressure: switch between open, random, sparse and long-stall modes
	initial begin : verdict_stall
		int mode;
		int left;
		verdict.ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(10, 80);
			end
			left--;
			case (mode)
				0: verdict.ready <= 1'b1;
				1: verdict.ready <= 1'($urandom_range(0, 1));
				2: verdict.ready <= (left % 5 == 0);
				default: verdict.ready <= (left < 4);
			endcase
		end
	end

	// Offer one byte; idle between bursts of random length
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			stream.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 160)
				: $urandom_range(1, 24);
		end
		burst_left--;
		stream.valid <= 1'b1;
		stream.data_byte <= b;
		stream.end_of_buffer <= last;
		do @(posedge clk); while (stream.ready !== 1'b1);
	endtask

	task automatic send_buffer(input byte_seq_t seq);
		foreach (seq[i])
			send_byte(seq[i], i == seq.size() - 1);
		taken_items += (seq.size() > 32) ? 32 : seq.size();
		buffers_sent++;
	endtask

	// Hold the register channel valid until the write goes through
	task automatic write_reg(input logic [3:0] idx, input logic [11:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
	endtask

	// Drop the stream and wait until every verdict is back and the pipe is empty
	task automatic settle();
		stream.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// first, first + step, ...; step zero repeats one byte
	function automatic byte_seq_t ramp(input int len, input logic [7:0] first,
		input logic [7:0] step);
		byte_seq_t seq;
		logic [7:0] b;
		b = first;
		for (int i = 0; i < len; i++) begin
			seq.push_back(b);
			b += step;
		end
		return seq;
	endfunction

	// Mostly full windows; contents random, from a small alphabet, rich in 0x00/0xFF,
	// or a stride over distinct values
	function automatic byte_seq_t random_buffer();
		byte_seq_t  seq;
		logic [7:0] alphabet [32];
		logic [7:0] b;
		logic [7:0] step;
		int         len;
		int         style;
		int         k;
		case ($urandom_range(0, 19))
			0, 1, 2: len = $urandom_range(1, 31);
			3, 4, 5: len = $urandom_range(33, 48);
			default: len = 32;
		endcase
		style = $urandom_range(0, 3);
		k = $urandom_range(1, 32);
		foreach (alphabet[i])
			alphabet[i] = 8'($urandom);
		b = 8'($urandom);
		step = 8'($urandom) | 8'd1;
		for (int i = 0; i < len; i++) begin
			case (style)
				0: seq.push_back(8'($urandom));
				1: seq.push_back(alphabet[$urandom_range(0, k - 1)]);
				2: begin
					case ($urandom_range(0, 7))
						0: seq.push_back(BYTE_ZERO);
						1: seq.push_back(BYTE_ONES);
						default: seq.push_back(8'($urandom));
					endcase
				end
				default: begin
					seq.push_back(b);
					b += step;
				end
			endcase
		end
		return seq;
	endfunction

	// Pick a fresh register setting, extremes included
	task automatic shuffle_config();
		logic [11:0] v;
		case ($urandom_range(0, 5))
			0: v = 12'd0;
			1: v = 12'd1280;
			2: v = 12'd1281;
			3: v = 12'hFFF;
			4: v = 12'($urandom_range(700, 1280));
			default: v = 12'($urandom);
		endcase
		write_reg(CFG_ENTROPY_THRESHOLD, v);
		for (int r = 1; r <= 3; r++) begin
			case ($urandom_range(0, 3))
				0: v = 12'd0;
				1: v = 12'd32;
				2: v = (r == 3) ? 12'($urandom_range(8, 32)) : 12'($urandom_range(0, 6));
				default: v = 12'($urandom);
			endcase
			case (r)
				1: write_reg(CFG_MAX_ZERO_BYTES, v);
				2: write_reg(CFG_MAX_ONES_BYTES, v);
				default: write_reg(CFG_MIN_DISTINCT, v);
			endcase
		end
		if ($urandom_range(0, 1) == 1)
			write_reg(4'($urandom_range(4, 15)), 12'($urandom));
		cfg.valid <= 1'b0;
	endtask

	initial begin : stimulus
		byte_seq_t seq;
		int        item_goal;
		int        verdict_goal;
		int        phase_goal;
		arst_n = 1'b0;
		stream.valid = 1'b0;
		stream.data_byte = '0;
		stream.end_of_buffer = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: lone byte is short, a full window misses the threshold
		send_buffer(ramp(1, 8'hFF, 8'h00));
		send_buffer(ramp(32, 8'h01, 8'h01));
		settle();

		write_reg(CFG_ENTROPY_THRESHOLD, 12'd1280);
		write_reg(CFG_MIN_DISTINCT, 12'd32);
		write_reg(4'd15, 12'hFFF);
		write_reg(4'd4, 12'h000);
		cfg.valid <= 1'b0;
		// all distinct at the top threshold, long buffer with ignored tail,
		// a single repeated value, one byte short
		send_buffer(ramp(32, 8'h01, 8'h01));
		seq = ramp(32, 8'h40, 8'h01);
		repeat (8) seq.push_back(BYTE_ZERO);
		send_buffer(seq);
		send_buffer(ramp(32, 8'hAA, 8'h00));
		send_buffer(ramp(31, 8'h80, 8'h01));
		settle();

		// Upper register bits are masked away
		write_reg(CFG_ENTROPY_THRESHOLD, 12'd0);
		write_reg(CFG_MAX_ZERO_BYTES, 12'hFC0);
		write_reg(CFG_MAX_ONES_BYTES, 12'd0);
		cfg.valid <= 1'b0;
		// one 0x00, one 0xFF, clean pass, one value short of distinct
		seq = ramp(31, 8'h01, 8'h01);
		seq.push_front(BYTE_ZERO);
		send_buffer(seq);
		seq = ramp(31, 8'h01, 8'h01);
		seq.push_back(BYTE_ONES);
		send_buffer(seq);
		send_buffer(ramp(32, 8'h10, 8'h01));
		seq = ramp(31, 8'h01, 8'h01);
		seq.push_back(8'h01);
		send_buffer(seq);
		settle();

		// Unreachable threshold, then none at all, with the loosest tallies
		write_reg(CFG_ENTROPY_THRESHOLD, 12'hFFF);
		write_reg(CFG_MAX_ZERO_BYTES, 12'd32);
		write_reg(CFG_MAX_ONES_BYTES, 12'd32);
		write_reg(CFG_MIN_DISTINCT, 12'd0);
		cfg.valid <= 1'b0;
		send_buffer(ramp(32, BYTE_ZERO, 8'h00));
		send_buffer(ramp(32, BYTE_ONES, 8'h00));
		settle();
		write_reg(CFG_ENTROPY_THRESHOLD, 12'd0);
		cfg.valid <= 1'b0;
		send_buffer(ramp(32, BYTE_ZERO, 8'h00));
		send_buffer(ramp(32, BYTE_ONES, 8'h00));

		// Random phases, each under its own register setting
		item_goal = taken_items + RANDOM_ITEMS;
		verdict_goal = buffers_sent + MIN_VERDICTS;
		while (taken_items < item_goal || buffers_sent < verdict_goal) begin
			settle();
			shuffle_config();
			phase_goal = taken_items + $urandom_range(80, 160);
			while (taken_items < phase_goal)
				send_buffer(random_buffer());
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
src/rkw_pkg.sv
src/rkw_ifs.sv
src/rkw_hist.sv
src/random_key_window_detector.sv
bench/rkw_verdict_checker.sv
bench/random_key_window_detector_tb.sv
